// ===== src/aob_pkg.sv =====
// Shared types, constants and divide-by-255 helpers for the alpha-over blend.
// No dependencies; imported by every module of the block.
package aob_pkg;

    localparam int ChanW     = 8;
    localparam int NumColour = 3;
    localparam int ChAlpha   = 3;
    localparam int QuoW      = 8;

    // ceil(2^32 / 255): exact quotient for every product of the blend
    localparam logic [24:0] Recip255 = 25'd16843010;

    typedef logic [ChanW-1:0]         t_chan;
    typedef t_chan [ChAlpha:0]        t_pix;     // red, green, blue, alpha from index 0
    typedef logic [16:0]              t_num;
    typedef t_num [NumColour-1:0]     t_num3;
    typedef t_chan [NumColour-1:0]    t_quo3;

    typedef enum logic [1:0] {
        MODE_DST,
        MODE_SRC,
        MODE_BLEND
    } t_mode;

    typedef struct packed {
        t_mode mode;
        t_pix  alt;
    } t_side;

    // x / 255 for x below 65280, so that the quotient fits eight bits
    function automatic t_chan div255_16(input logic [16:0] x);
        logic [16:0] s;
        s = x + 17'd1 + {8'd0, x[16:8]};
        return s[15:8];
    endfunction

    // x / 255 for x up to 255 * 255 * 255
    function automatic logic [15:0] div255_24(input logic [23:0] x);
        logic [48:0] p;
        p = 49'(x) * 49'(Recip255);
        return p[47:32];
    endfunction

endpackage

// ===== src/alpha_over_blend_8bit.sv =====
// Alpha-over blend, 8-bit RGBA: top level with opacity register and output register.
// Instantiates aob_alpha and aob_div; depends on aob_pkg.
//
// One source and one destination pixel go in per item and one blended pixel comes out.
// The block takes one item every clock cycle while the output side keeps taking results; the
// depth from an accepted item to its result is six stages of alpha and product arithmetic, nine
// stages of the bit-per-stage divider by output alpha, and the output register. Each
// stage stalls on its own, so bubbles are squeezed out when the output side holds off.
// Write the opacity only while no item is in flight; it resets to 255.
module alpha_over_blend_8bit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0] o_m_axis_tdata
);
    import aob_pkg::*;

    t_chan  r_opacity;
    logic   a_valid, a_ready;
    t_num3  a_num;
    t_chan  a_oa;
    t_side  a_side;
    logic   d_valid;
    t_quo3  d_quo;
    t_side  d_side;
    logic   out_en;
    logic   r_out_vld;
    t_pix   r_out;
    t_pix   n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= 8'd255;
        end else if (i_cfg_wr_en) begin
            r_opacity <= i_cfg_wr_data;
        end
    end

    aob_alpha u_alpha (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_src     (i_s_axis_tdata[31:0]),
        .i_dst     (i_s_axis_tdata[63:32]),
        .i_opacity (r_opacity),
        .o_valid   (a_valid),
        .i_ready   (a_ready),
        .o_num     (a_num),
        .o_oa      (a_oa),
        .o_side    (a_side)
    );

    aob_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (a_valid),
        .o_ready (a_ready),
        .i_num   (a_num),
        .i_oa    (a_oa),
        .i_side  (a_side),
        .o_valid (d_valid),
        .i_ready (out_en),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    assign out_en = !r_out_vld || i_m_axis_tready;

    always_comb begin
        n_out = d_side.alt;
        case (d_side.mode)
            MODE_BLEND: begin
                for (int k = 0; k < NumColour; k++) begin
                    n_out[k] = d_quo[k];
                end
            end
            default: begin
                n_out = d_side.alt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

// ===== src/aob_alpha.sv =====
// Alpha front end: effective alpha, output alpha, blend numerators, mode select.
// Six register stages with per-stage valid and stall; depends on aob_pkg.
module aob_alpha (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aob_pkg::t_pix      i_src,
    input  aob_pkg::t_pix      i_dst,
    input  aob_pkg::t_chan     i_opacity,
    output logic               o_valid,
    input  logic               i_ready,
    output aob_pkg::t_num3     o_num,
    output aob_pkg::t_chan     o_oa,
    output aob_pkg::t_side     o_side
);
    import aob_pkg::*;

    localparam int Stages = 6;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] en;

    t_pix              r1_src, r1_dst;
    logic [15:0]       r1_sa_op;

    t_pix              r2_src, r2_dst;
    t_chan             r2_ea;
    t_side             r2_side;
    t_chan             n2_ea;
    t_side             n2_side;

    logic [15:0]       r3_t;
    logic [2:0][15:0]  r3_u, r3_se;
    t_chan             r3_ea, r3_ia;
    t_side             r3_side;

    t_chan             r4_oa;
    logic [2:0][23:0]  r4_v;
    logic [2:0][15:0]  r4_se;
    t_side             r4_side;
    t_chan             n4_oa;
    t_side             n4_side;

    logic [2:0][15:0]  r5_q, r5_se;
    t_chan             r5_oa;
    t_side             r5_side;

    t_num3             r6_num;
    t_chan             r6_oa;
    t_side             r6_side;

    always_comb begin
        en[Stages-1] = !r_vld[Stages-1] || i_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    always_comb begin
        n2_ea = div255_16({1'b0, r1_sa_op} + 17'd127);
        n2_side.alt = {n2_ea, r1_src[2], r1_src[1], r1_src[0]};
        if (n2_ea == '0) begin
            n2_side.mode = MODE_DST;
            n2_side.alt  = r1_dst;
        end else if (n2_ea == 8'd255 || r1_dst[ChAlpha] == '0) begin
            n2_side.mode = MODE_SRC;
        end else begin
            n2_side.mode = MODE_BLEND;
        end
    end

    always_comb begin
        n4_oa   = r3_ea + div255_16({1'b0, r3_t} + 17'd127);
        n4_side = r3_side;
        if (r3_side.mode == MODE_BLEND) begin
            n4_side.alt[ChAlpha] = n4_oa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_src   <= i_src;
            r1_dst   <= i_dst;
            r1_sa_op <= 16'(i_src[ChAlpha]) * 16'(i_opacity);
        end
        if (en[1]) begin
            r2_src  <= r1_src;
            r2_dst  <= r1_dst;
            r2_ea   <= n2_ea;
            r2_side <= n2_side;
        end
        if (en[2]) begin
            r3_t    <= 16'(r2_dst[ChAlpha]) * 16'(8'd255 - r2_ea);
            r3_ea   <= r2_ea;
            r3_ia   <= ~r2_ea;
            r3_side <= r2_side;
            for (int k = 0; k < NumColour; k++) begin
                r3_u[k]  <= 16'(r2_dst[k]) * 16'(r2_dst[ChAlpha]);
                r3_se[k] <= 16'(r2_src[k]) * 16'(r2_ea);
            end
        end
        if (en[3]) begin
            r4_oa   <= n4_oa;
            r4_se   <= r3_se;
            r4_side <= n4_side;
            for (int k = 0; k < NumColour; k++) begin
                r4_v[k] <= 24'(r3_u[k]) * 24'(r3_ia);
            end
        end
        if (en[4]) begin
            r5_oa   <= r4_oa;
            r5_se   <= r4_se;
            r5_side <= r4_side;
            for (int k = 0; k < NumColour; k++) begin
                r5_q[k] <= div255_24(r4_v[k]);
            end
        end
        if (en[5]) begin
            r6_oa   <= r5_oa;
            r6_side <= r5_side;
            for (int k = 0; k < NumColour; k++) begin
                r6_num[k] <= {1'b0, r5_se[k]} + {1'b0, r5_q[k]};
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[Stages-1];
    assign o_num   = r6_num;
    assign o_oa    = r6_oa;
    assign o_side  = r6_side;

endmodule

// ===== src/aob_div.sv =====
// Pipelined restoring divider: colour numerator by output alpha, one quotient bit a stage.
// Overflow check stage first, quotient saturates to 255; depends on aob_pkg.
module aob_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aob_pkg::t_num3     i_num,
    input  aob_pkg::t_chan     i_oa,
    input  aob_pkg::t_side     i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output aob_pkg::t_quo3     o_quo,
    output aob_pkg::t_side     o_side
);
    import aob_pkg::*;

    localparam int Stages = QuoW + 1;

    logic [Stages-1:0]                 r_vld;
    logic [Stages-1:0]                 en;
    logic [Stages-1:0][2:0][15:0]      r_rem;
    logic [Stages-1:0][2:0][QuoW-1:0]  r_quo;
    logic [Stages-1:0][2:0]            r_ovf;
    t_chan                             r_oa   [Stages];
    t_side                             r_side [Stages];
    logic [Stages-1:0][2:0][15:0]      n_rem;
    logic [Stages-1:0][2:0][QuoW-1:0]  n_quo;

    always_comb begin
        en[Stages-1] = !r_vld[Stages-1] || i_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    always_comb begin
        logic [15:0] dvs;
        n_rem = '0;
        n_quo = '0;
        for (int j = 1; j < Stages; j++) begin
            dvs = 16'(r_oa[j-1]) << (QuoW - j);
            for (int k = 0; k < NumColour; k++) begin
                n_rem[j][k] = r_rem[j-1][k];
                n_quo[j][k] = r_quo[j-1][k];
                if (r_rem[j-1][k] >= dvs) begin
                    n_rem[j][k] = r_rem[j-1][k] - dvs;
                    n_quo[j][k][3'(QuoW - j)] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_oa[0]   <= i_oa;
            r_side[0] <= i_side;
            for (int k = 0; k < NumColour; k++) begin
                r_ovf[0][k] <= i_num[k] >= {1'b0, i_oa, 8'd0};
                r_rem[0][k] <= i_num[k][15:0];
                r_quo[0][k] <= '0;
            end
        end
        for (int j = 1; j < Stages; j++) begin
            if (en[j]) begin
                r_oa[j]   <= r_oa[j-1];
                r_side[j] <= r_side[j-1];
                r_ovf[j]  <= r_ovf[j-1];
                r_rem[j]  <= n_rem[j];
                r_quo[j]  <= n_quo[j];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NumColour; k++) begin
            o_quo[k] = r_ovf[Stages-1][k] ? 8'hFF : r_quo[Stages-1][k];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[Stages-1];
    assign o_side  = r_side[Stages-1];

endmodule
